### rtl/core/rlepal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlepal_pkg
// Shared types, codes and constants of the run-length palette decoder.
// ----------------------------------------------------------------------------
package rlepal_pkg;

  // Request kinds carried in the input tuser field.
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  // Result status codes carried in the output tuser field.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_IGNORED   = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam int unsigned DIM_W     = 12;
  localparam int unsigned SIZE_W    = 2 * DIM_W;
  localparam int unsigned LEN_W     = 14;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned PAL_DEPTH = 256;

  // Default frame size limit in pixels.
  localparam int unsigned MAX_PIXELS_DEF = 2097152;

  // Palette index that stands for a fully transparent pixel.
  localparam logic [IDX_W-1:0] COLOR_TRANSPARENT = 8'hFF;

  // BT.601 coefficients scaled by 1024.
  localparam int unsigned SUM_W = 21;
  localparam logic signed [12:0] COEF_Y   = 13'sd1192;
  localparam logic signed [12:0] COEF_RCR = 13'sd1634;
  localparam logic signed [12:0] COEF_GCB = -13'sd401;
  localparam logic signed [12:0] COEF_GCR = -13'sd833;
  localparam logic signed [12:0] COEF_BCB = 13'sd2065;
  localparam logic signed [9:0]  LUMA_OFS   = 10'sd16;
  localparam logic signed [9:0]  CHROMA_OFS = 10'sd128;

  // Depth of the output word buffer.
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] blue_diff;
    logic [7:0] red_diff;
    logic [7:0] alpha;
  } pal_entry_t;

  // Run control that travels alongside the palette lookup.
  typedef struct packed {
    logic             color_en;
    logic [LEN_W-1:0] run_count;
    logic             frame_last;
    logic [1:0]       status;
  } run_ctrl_t;

  typedef struct packed {
    logic [7:0]       pix_alpha;
    logic [7:0]       pix_red;
    logic [7:0]       pix_green;
    logic [7:0]       pix_blue;
    logic [LEN_W-1:0] run_count;
    logic             frame_last;
    logic [1:0]       status;
  } out_word_t;

endpackage

### rtl/core/rlepal_palette.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlepal_palette
// Palette memory of Y, Cb, Cr and alpha with one write and one registered read.
// ----------------------------------------------------------------------------
module rlepal_palette
  import rlepal_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  pal_entry_t       wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output pal_entry_t       rdata_o
);

  pal_entry_t mem_q [PAL_DEPTH];
  pal_entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/rlepal_csc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlepal_csc
// BT.601 YCbCr to ARGB conversion: registered channel sums, then clamping.
// ----------------------------------------------------------------------------
module rlepal_csc
  import rlepal_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  run_ctrl_t  ctrl_i,
  input  pal_entry_t entry_i,
  output logic       valid_o,
  output out_word_t  word_o
);

  logic signed [9:0]       y_s, cb_s, cr_s;
  logic signed [SUM_W-1:0] sum_r_d, sum_g_d, sum_b_d;
  logic signed [SUM_W-1:0] sum_r_q, sum_g_q, sum_b_q;
  logic [7:0]              alpha_q;
  run_ctrl_t               ctrl_q;
  logic                    valid_q;

  // A non-positive sum gives zero; otherwise truncate and saturate at 255.
  function automatic logic [7:0] clamp_channel(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-11:0] q;
    q = s[SUM_W-1:10];
    if (s <= 0) begin
      return 8'd0;
    end else if (q > (SUM_W-10)'(255)) begin
      return 8'hFF;
    end else begin
      return q[7:0];
    end
  endfunction

  // Remove the offsets from the palette components.
  assign y_s  = $signed({2'b00, entry_i.luma}) - LUMA_OFS;
  assign cb_s = $signed({2'b00, entry_i.blue_diff}) - CHROMA_OFS;
  assign cr_s = $signed({2'b00, entry_i.red_diff}) - CHROMA_OFS;

  // Constant multiplies and channel sums.
  assign sum_r_d = SUM_W'(y_s) * SUM_W'(COEF_Y) + SUM_W'(cr_s) * SUM_W'(COEF_RCR);
  assign sum_g_d = SUM_W'(y_s) * SUM_W'(COEF_Y) + SUM_W'(cb_s) * SUM_W'(COEF_GCB)
                 + SUM_W'(cr_s) * SUM_W'(COEF_GCR);
  assign sum_b_d = SUM_W'(y_s) * SUM_W'(COEF_Y) + SUM_W'(cb_s) * SUM_W'(COEF_BCB);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      sum_r_q <= sum_r_d;
      sum_g_q <= sum_g_d;
      sum_b_q <= sum_b_d;
      alpha_q <= entry_i.alpha;
      ctrl_q  <= ctrl_i;
    end
  end

  // Clamp and blank the color of transparent runs and status results.
  always_comb begin
    word_o.run_count  = ctrl_q.run_count;
    word_o.frame_last = ctrl_q.frame_last;
    word_o.status     = ctrl_q.status;
    if (ctrl_q.color_en) begin
      word_o.pix_alpha = alpha_q;
      word_o.pix_red   = clamp_channel(sum_r_q);
      word_o.pix_green = clamp_channel(sum_g_q);
      word_o.pix_blue  = clamp_channel(sum_b_q);
    end else begin
      word_o.pix_alpha = 8'd0;
      word_o.pix_red   = 8'd0;
      word_o.pix_green = 8'd0;
      word_o.pix_blue  = 8'd0;
    end
  end

  assign valid_o = valid_q;

endmodule

### rtl/core/rlepal_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlepal_out_buf
// Small output word buffer that decouples the pipeline from the consumer.
// ----------------------------------------------------------------------------
module rlepal_out_buf
  import rlepal_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  out_word_t            word_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output out_word_t            word_o,
  output logic [OUT_CNT_W-1:0] count_o
);

  out_word_t              buf_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0]   count_q;

  // Storage; the pipeline never pushes into a full buffer.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= word_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + OUT_CNT_W'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - OUT_CNT_W'(1);
      end
    end
  end

  assign valid_o = (count_q != '0);
  assign word_o  = buf_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

### rtl/core/rle_palette_ycbcr_run_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_palette_ycbcr_run_decoder
// Run-length palette decoder for subtitle graphics, YCbCr palette to ARGB.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while it is ready: palette loads,
// frame starts and run elements. Frame bookkeeping is done in the cycle a word
// is accepted; a run reads the palette memory, whose read is registered, the
// channel sums are registered and the clamped result is written into a
// four-word output buffer, from which it is offered to the consumer.
// The input stays ready at one word per cycle as long as results are taken;
// it drops only when the output buffer plus the results still in flight
// reach four words while the consumer stalls. Palette entries must be loaded
// before a run refers to them; there is no clearing pass after reset.
module rle_palette_ycbcr_run_decoder
  import rlepal_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  // Input stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata fields from bit 0: entry_index, entry_luma, entry_blue_diff,
  // entry_red_diff, entry_alpha, run_length, run_color, two zero bits.
  input  logic [63:0]          s_axis_tdata,
  // tuser fields from bit 0: req_type.
  input  logic [1:0]           s_axis_tuser,
  // Output stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata fields from bit 0: pix_alpha, pix_red, pix_green, pix_blue,
  // run_count, two zero bits.
  output logic [47:0]          m_axis_tdata,
  // tuser fields from bit 0: status.
  output logic [1:0]           m_axis_tuser,
  output logic                 m_axis_tlast
);

  localparam int unsigned PIX_W = $clog2(MAX_PIXELS + 1);
  localparam int unsigned CMP_W = (PIX_W > LEN_W) ? PIX_W : LEN_W;

  // Input word fields.
  logic [1:0]       req_type;
  logic [IDX_W-1:0] entry_index;
  pal_entry_t       entry_in;
  logic [LEN_W-1:0] run_length;
  logic [IDX_W-1:0] run_color;

  assign req_type            = s_axis_tuser;
  assign entry_index         = s_axis_tdata[7:0];
  assign entry_in.luma       = s_axis_tdata[15:8];
  assign entry_in.blue_diff  = s_axis_tdata[23:16];
  assign entry_in.red_diff   = s_axis_tdata[31:24];
  assign entry_in.alpha      = s_axis_tdata[39:32];
  assign run_length          = s_axis_tdata[53:40];
  assign run_color           = s_axis_tdata[61:54];

  logic                 in_acc;
  logic [DIM_W-1:0]     frame_width_q, frame_height_q;
  logic [PIX_W-1:0]     pixels_left_q, pixels_left_d;
  logic                 frame_open_q, frame_open_d;
  logic                 s1_valid_q, s1_valid_d;
  run_ctrl_t            s1_ctrl_q, s1_ctrl_d;
  logic                 pal_we, pal_re;
  pal_entry_t           pal_rdata;
  logic                 csc_valid;
  out_word_t            csc_word;
  logic                 out_valid;
  out_word_t            out_word;
  logic                 out_pop;
  logic [OUT_CNT_W-1:0] out_count;
  logic [OUT_CNT_W:0]   occupancy;
  logic [SIZE_W-1:0]    frame_size;
  logic                 too_large;
  logic [CMP_W-1:0]     len_ext, left_ext, left_new;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= '0;
      frame_height_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
      endcase
    end
  end

  // Frame size check and run clipping.
  assign frame_size = frame_width_q * frame_height_q;
  assign too_large  = frame_size > SIZE_W'(MAX_PIXELS);
  assign len_ext    = CMP_W'(run_length);
  assign left_ext   = CMP_W'(pixels_left_q);

  always_comb begin
    pixels_left_d = pixels_left_q;
    frame_open_d  = frame_open_q;
    s1_valid_d    = 1'b0;
    s1_ctrl_d     = '0;
    pal_we        = 1'b0;
    pal_re        = 1'b0;
    left_new      = left_ext;
    if (in_acc) begin
      unique case (req_type)
        REQ_LOAD: begin
          pal_we = 1'b1;
        end
        REQ_START: begin
          if (too_large) begin
            pixels_left_d    = '0;
            frame_open_d     = 1'b0;
            s1_valid_d       = 1'b1;
            s1_ctrl_d.status = ST_TOO_LARGE;
          end else begin
            pixels_left_d = frame_size[PIX_W-1:0];
            frame_open_d  = (frame_size != '0);
          end
        end
        REQ_RUN: begin
          s1_valid_d = 1'b1;
          if (!frame_open_q || pixels_left_q == '0) begin
            s1_ctrl_d.status = ST_IGNORED;
          end else begin
            pal_re = 1'b1;
            if (len_ext > left_ext) begin
              s1_ctrl_d.run_count = left_ext[LEN_W-1:0];
            end else begin
              s1_ctrl_d.run_count = run_length;
            end
            left_new             = left_ext - CMP_W'(s1_ctrl_d.run_count);
            pixels_left_d        = left_new[PIX_W-1:0];
            s1_ctrl_d.frame_last = (left_new == '0);
            s1_ctrl_d.color_en   = (run_color != COLOR_TRANSPARENT);
            s1_ctrl_d.status     = ST_OK;
            if (left_new == '0) begin
              frame_open_d = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixels_left_q <= '0;
      frame_open_q  <= 1'b0;
      s1_valid_q    <= 1'b0;
    end else begin
      pixels_left_q <= pixels_left_d;
      frame_open_q  <= frame_open_d;
      s1_valid_q    <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_d) begin
      s1_ctrl_q <= s1_ctrl_d;
    end
  end

  // Palette memory, looked up by the run color.
  rlepal_palette u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (entry_index),
    .wdata_i (entry_in),
    .re_i    (pal_re),
    .raddr_i (run_color),
    .rdata_o (pal_rdata)
  );

  // Color conversion.
  rlepal_csc u_csc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .ctrl_i  (s1_ctrl_q),
    .entry_i (pal_rdata),
    .valid_o (csc_valid),
    .word_o  (csc_word)
  );

  // Output buffer.
  assign out_pop = m_axis_tvalid && m_axis_tready;

  rlepal_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (csc_valid),
    .word_i  (csc_word),
    .pop_i   (out_pop),
    .valid_o (out_valid),
    .word_o  (out_word),
    .count_o (out_count)
  );

  // Accept a word only while every result in flight has a buffer slot.
  assign occupancy = (OUT_CNT_W + 1)'(out_count) + (OUT_CNT_W + 1)'(s1_valid_q)
                   + (OUT_CNT_W + 1)'(csc_valid);
  assign s_axis_tready = occupancy < (OUT_CNT_W + 1)'(OUT_DEPTH);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_word.run_count, out_word.pix_blue,
                          out_word.pix_green, out_word.pix_red, out_word.pix_alpha};
  assign m_axis_tuser  = out_word.status;
  assign m_axis_tlast  = out_word.frame_last;

  // An open frame always has pixels left.
  a_open_has_pixels : assert property (
    @(posedge clk_i) disable iff (!rst_ni) frame_open_q |-> (pixels_left_q != '0))
    else $error("frame open with no pixels left");

  // The buffer never receives a word while it is full.
  a_no_overflow : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    csc_valid |-> (out_count < OUT_CNT_W'(OUT_DEPTH) || out_pop))
    else $error("output buffer overflow");

  // Status results carry no pixels and never close a frame.
  a_status_clean : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ST_OK)
      |-> (m_axis_tdata == '0 && !m_axis_tlast))
    else $error("status result with payload");

  // A run that closes the frame leaves no pixels and no open frame.
  a_last_closes : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_d && s1_ctrl_d.frame_last) |=> (!frame_open_q && pixels_left_q == '0))
    else $error("frame not closed after last run");

  // A run accepted into an open frame never takes more than was left.
  a_clip : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (pal_re) |-> (CMP_W'(s1_ctrl_d.run_count) <= left_ext))
    else $error("run count exceeds remaining pixels");

endmodule
